// File: rtl/dmsrt_pkg.sv
`default_nettype none
package dmsrt_pkg;

  localparam int DEF_INDEX_BITS = 10;
  localparam int KEY_W          = 64;
  localparam int TAG_W          = 16;
  localparam int TAG_SHIFT      = 48;
  localparam int MOVE_W         = 16;
  localparam int SCORE_W        = 16;
  localparam int DEPTH_W        = 8;
  localparam int BOUND_W        = 2;
  localparam int AGE_W          = 8;
  localparam int OPC_W          = 2;

  // {tag, move}
  localparam int TM_W = TAG_W + MOVE_W;
  // {score, depth, bound, age}
  localparam int SM_W = SCORE_W + DEPTH_W + BOUND_W + AGE_W;

  localparam logic [OPC_W-1:0] OP_PROBE = 2'd0;
  localparam logic [OPC_W-1:0] OP_STORE = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]          opcode;
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [BOUND_W-1:0]        bound_kind;
    logic [AGE_W-1:0]          age;
  } in_req_t;

  typedef struct packed {
    logic                      hit;
    logic [MOVE_W-1:0]         found_move;
    logic signed [SCORE_W-1:0] found_score;
    logic [DEPTH_W-1:0]        found_depth;
    logic [BOUND_W-1:0]        found_bound;
  } out_rsp_t;

endpackage
`default_nettype wire

// File: rtl/dmsrt_ram.sv
`default_nettype none
module dmsrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/direct_mapped_search_result_table_core.sv
// Direct-mapped search result table.
// Input channel (in_valid / in_stall / in_req) carries probe, store and clear
// requests; the result channel (out_valid / out_stall / out_rsp) returns one
// response per probe. Stores, clears and unused opcodes return nothing.
// A probe or store reads the entry in the accept cycle and finishes in the
// lookup state, with in_stall high. A probe response is written into the
// output register as the lookup ends and holds there while out_stall is
// high; the next request may be accepted meanwhile, but a following probe
// waits in its lookup cycle until the output register frees up.
// A clear walks the table writing zeros, one entry per cycle, and holds
// in_stall high until every entry is written. Reset (rst_n low, synchronous)
// drops any pending response and starts the same walk, so after reset the
// block accepts nothing until the walk is done.
// Both stores are synchronous RAMs with a registered read; store writes
// land at the end of the lookup cycle, before any later read is issued.
`default_nettype none
module direct_mapped_search_result_table_core #(
  parameter int INDEX_BITS = dmsrt_pkg::DEF_INDEX_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dmsrt_pkg::in_req_t in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dmsrt_pkg::out_rsp_t     out_rsp
);

  localparam int DEPTH = 1 << INDEX_BITS;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [INDEX_BITS-1:0] clr_idx_r, clr_idx_nxt;
  dmsrt_pkg::in_req_t    req_r;
  logic                  out_valid_r, out_valid_nxt;
  dmsrt_pkg::out_rsp_t   out_rsp_r, out_rsp_nxt;

  logic                        in_acc;
  logic                        out_free;
  logic                        we;
  logic [INDEX_BITS-1:0]       waddr;
  logic [dmsrt_pkg::TM_W-1:0]  tm_wdata, tm_rdata;
  logic [dmsrt_pkg::SM_W-1:0]  sm_wdata, sm_rdata;

  logic [dmsrt_pkg::TAG_W-1:0]   req_tag, old_tag;
  logic [dmsrt_pkg::DEPTH_W-1:0] old_depth;
  logic [dmsrt_pkg::AGE_W-1:0]   old_age;
  logic                          hit, replace;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign req_tag   = req_r.key[dmsrt_pkg::TAG_SHIFT +: dmsrt_pkg::TAG_W];
  assign old_tag   = tm_rdata[dmsrt_pkg::MOVE_W +: dmsrt_pkg::TAG_W];
  assign old_depth = sm_rdata[dmsrt_pkg::AGE_W + dmsrt_pkg::BOUND_W +: dmsrt_pkg::DEPTH_W];
  assign old_age   = sm_rdata[dmsrt_pkg::AGE_W-1:0];
  assign hit       = (old_tag == req_tag);
  assign replace   = hit || (old_age != req_r.age) || (req_r.depth > old_depth);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    we            = 1'b0;
    waddr         = req_r.key[INDEX_BITS-1:0];
    tm_wdata      = {req_tag, req_r.move};
    sm_wdata      = {req_r.score, req_r.depth, req_r.bound_kind, req_r.age};
    case (state_r)
      ST_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_idx_r;
        tm_wdata    = '0;
        sm_wdata    = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req.opcode)
            dmsrt_pkg::OP_PROBE: state_nxt = ST_LOOK;
            dmsrt_pkg::OP_STORE: state_nxt = ST_LOOK;
            dmsrt_pkg::OP_CLEAR: state_nxt = ST_CLEAR;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: begin
        if (req_r.opcode == dmsrt_pkg::OP_PROBE) begin
          if (out_free) begin
            out_valid_nxt           = 1'b1;
            out_rsp_nxt.hit         = hit;
            out_rsp_nxt.found_move  = hit ? tm_rdata[dmsrt_pkg::MOVE_W-1:0] : '0;
            out_rsp_nxt.found_score = hit ?
                sm_rdata[dmsrt_pkg::SM_W-1 -: dmsrt_pkg::SCORE_W] : '0;
            out_rsp_nxt.found_depth = hit ? old_depth : '0;
            out_rsp_nxt.found_bound = hit ?
                sm_rdata[dmsrt_pkg::AGE_W +: dmsrt_pkg::BOUND_W] : '0;
            state_nxt               = ST_IDLE;
          end
        end else begin
          we        = replace;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    if (in_acc) begin
      req_r <= in_req;
    end
  end

  dmsrt_ram #(
    .WIDTH (dmsrt_pkg::TM_W),
    .DEPTH (DEPTH)
  ) u_tm_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (tm_wdata),
    .re    (in_acc),
    .raddr (in_req.key[INDEX_BITS-1:0]),
    .rdata (tm_rdata)
  );

  dmsrt_ram #(
    .WIDTH (dmsrt_pkg::SM_W),
    .DEPTH (DEPTH)
  ) u_sm_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (sm_wdata),
    .re    (in_acc),
    .raddr (in_req.key[INDEX_BITS-1:0]),
    .rdata (sm_rdata)
  );

endmodule
`default_nettype wire
